// ===== src/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// shared types and constants of the page frame bitmap allocator
// ----------------------------------------------------------------------------
package pfba_pkg;

  // bitmap geometry
  localparam int NUM_FRAMES_DEF    = 32768;
  localparam int WORD_BITS         = 32;
  localparam int BIT_IDX_W         = 5;      // log2 of WORD_BITS
  localparam int RESET_USED_FRAMES = 8192;
  localparam int RESET_USED_WORDS  = RESET_USED_FRAMES / WORD_BITS;

  // field widths
  localparam int FRAME_W = 20;
  localparam int CMP_W   = FRAME_W + 1;      // holds frame counts up to 2**20
  localparam int CFG_W   = 16;
  localparam int LIN_W   = 32;

  // config port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // config reset values
  localparam logic [CFG_W-1:0] FIRST_RST = 16'd8192;
  localparam logic [CFG_W-1:0] END_RST   = 16'd32768;
  localparam logic [CFG_W-1:0] LIMIT_RST = 16'd8192;
  localparam logic [LIN_W-1:0] LOW_RST   = 32'hC000_0000;
  localparam logic [LIN_W-1:0] HIGH_RST  = 32'hC200_0000;

  typedef enum logic [2:0] {
    REG_FIRST  = 3'd0,
    REG_END    = 3'd1,
    REG_LIMIT  = 3'd2,
    REG_LOW    = 3'd3,
    REG_HIGH   = 3'd4,
    REG_UNLOCK = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_PROT    = 2'd2,
    STAT_OUTSIDE = 2'd3
  } status_e;

  typedef struct packed {
    logic [CFG_W-1:0] first_frame;
    logic [CFG_W-1:0] end_frame;
    logic [CFG_W-1:0] prot_limit;
    logic [LIN_W-1:0] lin_low;
    logic [LIN_W-1:0] lin_high;
    logic             unlock;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    status_e            status;
    logic               used;
  } res_t;

endpackage

// ===== src/pfba_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pfba_cfg_regs
// apb register file holding the allocator window and protection settings
// ----------------------------------------------------------------------------
module pfba_cfg_regs
  import pfba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FIRST:  cfg_d.first_frame = pwdata[CFG_W-1:0];
        REG_END:    cfg_d.end_frame   = pwdata[CFG_W-1:0];
        REG_LIMIT:  cfg_d.prot_limit  = pwdata[CFG_W-1:0];
        REG_LOW:    cfg_d.lin_low     = pwdata[LIN_W-1:0];
        REG_HIGH:   cfg_d.lin_high    = pwdata[LIN_W-1:0];
        REG_UNLOCK: cfg_d.unlock      = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST:  prdata = APB_DW'(cfg_q.first_frame);
      REG_END:    prdata = APB_DW'(cfg_q.end_frame);
      REG_LIMIT:  prdata = APB_DW'(cfg_q.prot_limit);
      REG_LOW:    prdata = APB_DW'(cfg_q.lin_low);
      REG_HIGH:   prdata = APB_DW'(cfg_q.lin_high);
      REG_UNLOCK: prdata = APB_DW'(cfg_q.unlock);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_frame <= FIRST_RST;
      cfg_q.end_frame   <= END_RST;
      cfg_q.prot_limit  <= LIMIT_RST;
      cfg_q.lin_low     <= LOW_RST;
      cfg_q.lin_high    <= HIGH_RST;
      cfg_q.unlock      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/pfba_engine.sv =====
// ----------------------------------------------------------------------------
// pfba_engine
// bitmap memory with clearing sweep, word scan and read-modify-write sequencer
// ----------------------------------------------------------------------------
module pfba_engine
  import pfba_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_op_i,
  input  logic [FRAME_W-1:0] in_frame_i,
  input  logic [LIN_W-1:0]   in_lin_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BITOP,
    ST_SCAN,
    ST_RESP
  } state_e;

  // bitmap storage
  logic [WORD_BITS-1:0] bitmap_mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  state_e             state_q, state_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  op_e                op_q, op_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [LIN_W-1:0]   lin_q, lin_d;
  logic [AW-1:0]      scan_addr_q, scan_addr_d;
  logic [AW-1:0]      chk_addr_q, chk_addr_d;
  logic               issue_q, issue_d;
  logic               chk_valid_q, chk_valid_d;
  res_t               res_q, res_d;

  // window and protection terms
  logic [CMP_W-1:0]     end_eff, end_m1, first_ext;
  logic [AW-1:0]        first_word, last_word, in_word;
  logic                 win_open;
  logic                 in_op_lin_lock, item_lin_lock;
  logic                 in_in_range, in_locked;
  op_e                  in_op;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, free_bits, bit_sel;
  logic [BIT_IDX_W-1:0] free_idx;
  logic                 found_lock, bitop_locked, cur_bit;
  logic [FRAME_W-1:0]   found_frame;

  assign in_op     = op_e'(in_op_i);
  assign first_ext = CMP_W'(cfg_i.first_frame);
  assign end_eff   = (CMP_W'(cfg_i.end_frame) < CMP_W'(NUM_FRAMES)) ?
                     CMP_W'(cfg_i.end_frame) : CMP_W'(NUM_FRAMES);
  assign end_m1    = end_eff - CMP_W'(1);
  assign win_open  = first_ext < end_eff;
  assign first_word = first_ext[AW+BIT_IDX_W-1:BIT_IDX_W];
  assign last_word  = end_m1[AW+BIT_IDX_W-1:BIT_IDX_W];

  assign in_in_range    = CMP_W'(in_frame_i) < CMP_W'(NUM_FRAMES);
  assign in_word        = in_frame_i[AW+BIT_IDX_W-1:BIT_IDX_W];
  assign in_op_lin_lock = !cfg_i.unlock && (in_lin_i > cfg_i.lin_low) &&
                          (in_lin_i < cfg_i.lin_high);
  assign item_lin_lock  = !cfg_i.unlock && (lin_q > cfg_i.lin_low) &&
                          (lin_q < cfg_i.lin_high);

  // query is never protected, free ignores the low frame limit
  always_comb begin
    case (in_op)
      OP_MARK: in_locked = in_op_lin_lock ||
                           (!cfg_i.unlock &&
                            (CMP_W'(in_frame_i) < CMP_W'(cfg_i.prot_limit)));
      OP_FREE: in_locked = in_op_lin_lock;
      default: in_locked = 1'b0;
    endcase
  end

  // scan word masking: trim below first frame and at or above the end frame
  assign lo_mask   = (chk_addr_q == first_word) ?
                     ({WORD_BITS{1'b1}} << first_ext[BIT_IDX_W-1:0]) : '1;
  assign hi_mask   = (chk_addr_q == last_word) ?
                     ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) -
                                            end_m1[BIT_IDX_W-1:0])) : '1;
  assign free_bits = ~rd_data_q & lo_mask & hi_mask;

  // lowest free bit
  always_comb begin
    free_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_idx = BIT_IDX_W'(b);
      end
    end
  end

  assign found_frame = FRAME_W'({chk_addr_q, free_idx});
  assign found_lock  = item_lin_lock ||
                       (!cfg_i.unlock &&
                        (CMP_W'(found_frame) < CMP_W'(cfg_i.prot_limit)));

  assign bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << frame_q[BIT_IDX_W-1:0];
  assign cur_bit = |(rd_data_q & bit_sel);

  always_comb begin
    case (op_q)
      OP_MARK: bitop_locked = item_lin_lock ||
                              (!cfg_i.unlock &&
                               (CMP_W'(frame_q) < CMP_W'(cfg_i.prot_limit)));
      OP_FREE: bitop_locked = item_lin_lock;
      default: bitop_locked = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    op_d        = op_q;
    frame_d     = frame_q;
    lin_d       = lin_q;
    scan_addr_d = scan_addr_q;
    chk_addr_d  = chk_addr_q;
    issue_d     = issue_q;
    chk_valid_d = chk_valid_q;
    res_d       = res_q;
    mem_re      = 1'b0;
    mem_raddr   = scan_addr_q;
    mem_we      = 1'b0;
    mem_waddr   = chk_addr_q;
    mem_wdata   = rd_data_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = (CMP_W'(clr_addr_q) < CMP_W'(RESET_USED_WORDS)) ? '1 : '0;
        if (clr_addr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op;
          frame_d = in_frame_i;
          lin_d   = in_lin_i;
          if (in_op == OP_ALLOC) begin
            if (!win_open) begin
              res_d   = '{frame: '0, status: STAT_NO_FREE, used: 1'b0};
              state_d = ST_RESP;
            end else begin
              scan_addr_d = first_word;
              issue_d     = 1'b1;
              chk_valid_d = 1'b0;
              state_d     = ST_SCAN;
            end
          end else if (!in_in_range) begin
            res_d = '{frame: in_frame_i,
                      status: (in_locked ? STAT_PROT : STAT_OUTSIDE),
                      used: 1'b0};
            state_d = ST_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = in_word;
            chk_addr_d = in_word;
            state_d   = ST_BITOP;
          end
        end
      end
      ST_BITOP: begin
        res_d.frame = frame_q;
        if (op_q == OP_QUERY) begin
          res_d.status = STAT_OK;
          res_d.used   = cur_bit;
        end else if (bitop_locked) begin
          res_d.status = STAT_PROT;
          res_d.used   = cur_bit;
        end else begin
          mem_we       = 1'b1;
          mem_wdata    = (op_q == OP_MARK) ? (rd_data_q | bit_sel) :
                                             (rd_data_q & ~bit_sel);
          res_d.status = STAT_OK;
          res_d.used   = (op_q == OP_MARK);
        end
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        // one word read per cycle, its result checked in the next cycle
        mem_re = issue_q;
        if (issue_q) begin
          scan_addr_d = scan_addr_q + AW'(1);
          issue_d     = (scan_addr_q != last_word);
        end
        chk_addr_d  = scan_addr_q;
        chk_valid_d = issue_q;
        if (chk_valid_q) begin
          if (|free_bits) begin
            res_d.frame = found_frame;
            if (found_lock) begin
              res_d.status = STAT_PROT;
              res_d.used   = 1'b0;
            end else begin
              mem_we       = 1'b1;
              mem_wdata    = rd_data_q |
                             ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_idx);
              res_d.status = STAT_OK;
              res_d.used   = 1'b1;
            end
            state_d = ST_RESP;
          end else if (chk_addr_q == last_word) begin
            res_d   = '{frame: '0, status: STAT_NO_FREE, used: 1'b0};
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      op_q        <= OP_ALLOC;
      frame_q     <= '0;
      lin_q       <= '0;
      scan_addr_q <= '0;
      chk_addr_q  <= '0;
      issue_q     <= 1'b0;
      chk_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      op_q        <= op_d;
      frame_q     <= frame_d;
      lin_q       <= lin_d;
      scan_addr_q <= scan_addr_d;
      chk_addr_q  <= chk_addr_d;
      issue_q     <= issue_d;
      chk_valid_q <= chk_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bitmap_mem[mem_raddr];
    end
  end

endmodule

// ===== src/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// first-fit physical page frame allocator over a one-bit-per-frame bitmap
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request item: tuser is the operation (allocate, mark,
//   free, query), tdata the frame and the linear address for the protection
//   check. m_axis returns exactly one result item per request: tdata holds the
//   frame and its bitmap bit afterwards, tuser the status code.
//   the apb port sets the allocate window and the protection settings; write
//   it only while no request is in flight.
//   mark, free and query read the frame's bitmap word, check or update it in
//   the bit-operation state and pass their result through the response state
//   to the output register. allocate scans one 32-bit bitmap word per cycle
//   through the single read port of the bitmap ram, ceil(NUM_FRAMES / 32)
//   words at most; an empty window answers without a scan. one request is
//   worked on at a time; the next one is taken as soon as the previous
//   result has moved to the output register, even while that result waits
//   for m_axis_tready.
//   reset: the bitmap ram is swept one word per cycle over its
//   ceil(NUM_FRAMES / 32) words (1024 at the default size), marking frames
//   below 8192 used; no request is accepted during the sweep, apb writes are.
//   when the receiver stalls the result holds on m_axis and the engine waits
//   with its next result until the output register is free.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
  import pfba_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [55:0]       s_axis_tdata,   // frame[19:0], lin_addr[51:20], zero pad
  input  logic [1:0]        s_axis_tuser,   // operation[1:0]
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // result_frame[19:0], used_bit[20], zero pad
  output logic [1:0]        m_axis_tuser,   // status[1:0]
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t eng_res;
  logic eng_res_valid, eng_res_ready;

  // output register
  logic m_valid_q, m_valid_d;
  res_t m_res_q, m_res_d;

  pfba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfba_engine #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_frame_i  (s_axis_tdata[FRAME_W-1:0]),
    .in_lin_i    (s_axis_tdata[FRAME_W+LIN_W-1:FRAME_W]),
    .res_valid_o (eng_res_valid),
    .res_ready_i (eng_res_ready),
    .res_o       (eng_res)
  );

  // engine hands over when the output slot is empty or draining this cycle
  assign eng_res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (eng_res_valid && eng_res_ready) begin
      m_valid_d = 1'b1;
      m_res_d   = eng_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_res_q   <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      m_res_q   <= m_res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_res_q.used, m_res_q.frame};
  assign m_axis_tuser  = m_res_q.status;

endmodule
